FILE: design/sih_pkg.sv
// sih_pkg: shared constants for the symbol interning hash table.
// No dependencies.
package sih_pkg;

  localparam int KEY_W          = 64;
  localparam int DROP_W         = 32;
  localparam int SLOT_BITS_DEF  = 10;
  localparam int SYMBOL_CAP_DEF = 512;

  localparam logic [KEY_W-1:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [31:0]      GOLDEN_LO  = GOLDEN_MUL[31:0];
  localparam logic [31:0]      GOLDEN_HI  = GOLDEN_MUL[63:32];

  localparam logic KIND_INTERN = 1'b0;
  localparam logic KIND_READ   = 1'b1;

endpackage

FILE: design/symbol_interning_hash_table.sv
// symbol_interning_hash_table: interns 64-bit keys into dense indices through a
// Fibonacci-hashed, linearly probed slot table; also reads back keys by index.
// Depends on sih_pkg.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------
//  in       | in_kind, in_key, in_lookup_index        | accepted on start && !busy
//  out      | out_symbol_index .. out_drops_seen      | out_strobe, one cycle, no stall
//
// Intern: hashing in states M0, M1 and M2 on one shared 32x32 multiplier, slot read in
// PRB, then CHK steps through the probed slots one by one; result strobed the cycle busy
// falls. Read back: states RB then RBO. Key zero: result the next cycle, never busy.
// After reset the slot table is cleared, one slot per cycle; busy until it is all clear.
// The receiver cannot stall; each result is shown for exactly one cycle.
module symbol_interning_hash_table #(
  parameter int SLOT_BITS  = sih_pkg::SLOT_BITS_DEF,
  parameter int SYMBOL_CAP = sih_pkg::SYMBOL_CAP_DEF,
  parameter int IW = (SYMBOL_CAP > 1) ? $clog2(SYMBOL_CAP) : 1,
  parameter int HW = $clog2(SYMBOL_CAP + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [sih_pkg::KEY_W-1:0]   in_key,
  input  logic [IW-1:0]               in_lookup_index,
  output logic                        out_strobe,
  output logic [IW-1:0]               out_symbol_index,
  output logic                        out_valid_res,
  output logic                        out_newly_added,
  output logic [sih_pkg::KEY_W-1:0]   out_name_key,
  output logic [HW-1:0]               out_symbols_held,
  output logic [sih_pkg::DROP_W-1:0]  out_drops_seen
);
  import sih_pkg::*;

  localparam int SLOT_COUNT = 1 << SLOT_BITS;
  localparam int ENT_W      = KEY_W + IW;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_M0, ST_M1, ST_M2, ST_PRB, ST_CHK, ST_RB, ST_RBO
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic [SLOT_BITS-1:0] probe_cnt_r, probe_cnt_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [IW-1:0]        lookup_r, lookup_nxt;
  logic [KEY_W-1:0]     acc_r, acc_nxt;
  logic [HW-1:0]        total_r, total_nxt;
  logic [DROP_W-1:0]    drop_r, drop_nxt;

  logic                 strobe_r, strobe_nxt;
  logic [IW-1:0]        oidx_r, oidx_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic                 oadded_r, oadded_nxt;
  logic [KEY_W-1:0]     okey_r, okey_nxt;

  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_p;

  logic [ENT_W-1:0]     slot_mem [SLOT_COUNT];
  logic [ENT_W-1:0]     slot_q_r;
  logic                 slot_we;
  logic [SLOT_BITS-1:0] slot_wa;
  logic [ENT_W-1:0]     slot_wd;

  logic [KEY_W-1:0]     itk_mem [SYMBOL_CAP];
  logic [KEY_W-1:0]     itk_q_r;
  logic                 itk_we;

  logic [KEY_W-1:0]     q_key;
  logic [IW-1:0]        q_idx;

  assign q_key = slot_q_r[ENT_W-1 -: KEY_W];
  assign q_idx = slot_q_r[IW-1:0];
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    slot_nxt      = slot_r;
    probe_cnt_nxt = probe_cnt_r;
    key_nxt       = key_r;
    lookup_nxt    = lookup_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    drop_nxt      = drop_r;
    strobe_nxt    = 1'b0;
    oidx_nxt      = oidx_r;
    ovalid_nxt    = ovalid_r;
    oadded_nxt    = oadded_r;
    okey_nxt      = okey_r;
    slot_we       = 1'b0;
    slot_wa       = slot_r;
    slot_wd       = {key_r, total_r[IW-1:0]};
    itk_we        = 1'b0;
    mul_a         = key_r[31:0];
    mul_b         = GOLDEN_LO;
    case (state_r)
      ST_CLR: begin
        slot_we     = 1'b1;
        slot_wa     = clr_cnt_r;
        slot_wd     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          key_nxt    = in_key;
          lookup_nxt = in_lookup_index;
          if (in_kind == KIND_READ) begin
            state_nxt = ST_RB;
          end else if (in_key == '0) begin
            drop_nxt   = drop_r + 1'b1;
            strobe_nxt = 1'b1;
            oidx_nxt   = '0;
            ovalid_nxt = 1'b0;
            oadded_nxt = 1'b0;
            okey_nxt   = '0;
          end else begin
            state_nxt = ST_M0;
          end
        end
      end
      ST_M0: begin
        acc_nxt   = mul_p;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        mul_b     = GOLDEN_HI;
        acc_nxt   = acc_r + {mul_p[31:0], 32'b0};
        state_nxt = ST_M2;
      end
      ST_M2: begin
        mul_a     = key_r[63:32];
        acc_nxt   = acc_r + {mul_p[31:0], 32'b0};
        state_nxt = ST_PRB;
      end
      ST_PRB: begin
        slot_nxt      = acc_r[KEY_W-1 -: SLOT_BITS];
        probe_cnt_nxt = '0;
        state_nxt     = ST_CHK;
      end
      ST_CHK: begin
        if (q_key == key_r) begin
          strobe_nxt = 1'b1;
          oidx_nxt   = q_idx;
          ovalid_nxt = 1'b1;
          oadded_nxt = 1'b0;
          okey_nxt   = key_r;
          state_nxt  = ST_IDLE;
        end else if (q_key == '0) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
          if (total_r >= HW'(SYMBOL_CAP)) begin
            drop_nxt   = drop_r + 1'b1;
            oidx_nxt   = '0;
            ovalid_nxt = 1'b0;
            oadded_nxt = 1'b0;
            okey_nxt   = '0;
          end else begin
            slot_we    = 1'b1;
            itk_we     = 1'b1;
            total_nxt  = total_r + 1'b1;
            oidx_nxt   = total_r[IW-1:0];
            ovalid_nxt = 1'b1;
            oadded_nxt = 1'b1;
            okey_nxt   = key_r;
          end
        end else if (probe_cnt_r == '1) begin
          drop_nxt   = drop_r + 1'b1;
          strobe_nxt = 1'b1;
          oidx_nxt   = '0;
          ovalid_nxt = 1'b0;
          oadded_nxt = 1'b0;
          okey_nxt   = '0;
          state_nxt  = ST_IDLE;
        end else begin
          slot_nxt      = slot_r + 1'b1;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
        end
      end
      ST_RB: begin
        state_nxt = ST_RBO;
      end
      ST_RBO: begin
        strobe_nxt = 1'b1;
        oadded_nxt = 1'b0;
        state_nxt  = ST_IDLE;
        if (HW'(lookup_r) < total_r && HW'(lookup_r) < HW'(SYMBOL_CAP)) begin
          oidx_nxt   = lookup_r;
          ovalid_nxt = 1'b1;
          okey_nxt   = itk_q_r;
        end else begin
          oidx_nxt   = '0;
          ovalid_nxt = 1'b0;
          okey_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      drop_r      <= '0;
      strobe_r    <= 1'b0;
      slot_r      <= '0;
      probe_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      total_r     <= total_nxt;
      drop_r      <= drop_nxt;
      strobe_r    <= strobe_nxt;
      slot_r      <= slot_nxt;
      probe_cnt_r <= probe_cnt_nxt;
    end
    key_r    <= key_nxt;
    lookup_r <= lookup_nxt;
    acc_r    <= acc_nxt;
    oidx_r   <= oidx_nxt;
    ovalid_r <= ovalid_nxt;
    oadded_r <= oadded_nxt;
    okey_r   <= okey_nxt;
  end

  // slot table: {key, index}, read at the next probe slot every cycle
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_q_r <= slot_mem[slot_nxt];
  end

  always_ff @(posedge clk) begin
    if (itk_we) itk_mem[total_r[IW-1:0]] <= key_r;
    itk_q_r <= itk_mem[lookup_r];
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_symbol_index = oidx_r;
  assign out_valid_res    = ovalid_r;
  assign out_newly_added  = oadded_r;
  assign out_name_key     = okey_r;
  assign out_symbols_held = total_r;
  assign out_drops_seen   = drop_r;

endmodule

FILE: verif/testbench.sv
// Testbench for symbol_interning_hash_table: directed and random intern and
// read-back items, checked against a shadow slot table kept in the bench.
// Depends on sih_pkg and the symbol_interning_hash_table RTL.
`timescale 1ns / 100ps

module testbench;
  import sih_pkg::*;

  localparam int SLOT_BITS   = SLOT_BITS_DEF;
  localparam int SLOTS       = 1 << SLOT_BITS;
  localparam int SYMBOL_CAP  = SYMBOL_CAP_DEF;
  localparam int IDX_W       = $clog2(SYMBOL_CAP);
  localparam int HELD_W      = $clog2(SYMBOL_CAP + 1);
  localparam int STALL_LIMIT = 8192;
  localparam int DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [IDX_W-1:0]  sym_index;
    logic              valid;
    logic              added;
    logic [KEY_W-1:0]  name_key;
    logic [HELD_W-1:0] held;
    logic [DROP_W-1:0] drops;
  } reply_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_kind;
  logic [KEY_W-1:0]  in_key;
  logic [IDX_W-1:0]  in_lookup_index;
  logic              out_strobe;
  logic [IDX_W-1:0]  out_symbol_index;
  logic              out_valid_res;
  logic              out_newly_added;
  logic [KEY_W-1:0]  out_name_key;
  logic [HELD_W-1:0] out_symbols_held;
  logic [DROP_W-1:0] out_drops_seen;

  // shadow copy of the table
  logic [KEY_W-1:0]  shadow_slot_key [SLOTS];
  logic [IDX_W-1:0]  shadow_slot_idx [SLOTS];
  logic [KEY_W-1:0]  shadow_idx_key [SYMBOL_CAP];
  logic [HELD_W-1:0] shadow_held;
  logic [DROP_W-1:0] shadow_drops;

  reply_t replies_due[$];
  int     mismatches;
  int     items_sent;
  int     interns_sent;
  int     reads_sent;
  int     gap_pct;
  int     stall_cycles;

  symbol_interning_hash_table uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_lookup_index  (in_lookup_index),
    .out_strobe       (out_strobe),
    .out_symbol_index (out_symbol_index),
    .out_valid_res    (out_valid_res),
    .out_newly_added  (out_newly_added),
    .out_name_key     (out_name_key),
    .out_symbols_held (out_symbols_held),
    .out_drops_seen   (out_drops_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [SLOT_BITS-1:0] home_slot_of(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] prod;
    prod = k * GOLDEN_MUL;
    return prod[KEY_W-1 -: SLOT_BITS];
  endfunction

  // advances the shadow table by one item and returns its reply
  function automatic reply_t compute_reply(logic kind, logic [KEY_W-1:0] k,
                                           logic [IDX_W-1:0] lookup);
    reply_t r;
    logic [SLOT_BITS-1:0] slot;
    int probe;
    bit done;
    r = '0;
    done = 1'b0;
    if (kind == KIND_READ) begin
      if (lookup < shadow_held) begin
        r.sym_index = lookup;
        r.valid     = 1'b1;
        r.name_key  = shadow_idx_key[lookup];
      end
    end else if (k == '0) begin
      shadow_drops = shadow_drops + 1'b1;
    end else begin
      slot = home_slot_of(k);
      for (probe = 0; probe < SLOTS && !done; probe++) begin
        if (shadow_slot_key[slot] == k) begin
          r.sym_index = shadow_slot_idx[slot];
          r.valid     = 1'b1;
          r.name_key  = k;
          done = 1'b1;
        end else if (shadow_slot_key[slot] == '0) begin
          if (shadow_held >= SYMBOL_CAP) begin
            shadow_drops = shadow_drops + 1'b1;
          end else begin
            shadow_slot_key[slot] = k;
            shadow_slot_idx[slot] = shadow_held[IDX_W-1:0];
            shadow_idx_key[shadow_held[IDX_W-1:0]] = k;
            r.sym_index = shadow_held[IDX_W-1:0];
            r.valid     = 1'b1;
            r.added     = 1'b1;
            r.name_key  = k;
            shadow_held = shadow_held + 1'b1;
          end
          done = 1'b1;
        end else begin
          slot = slot + 1'b1;
        end
      end
      if (!done) shadow_drops = shadow_drops + 1'b1;
    end
    r.held  = shadow_held;
    r.drops = shadow_drops;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // called just after a falling edge; returns on a falling edge
  task automatic send_item(logic kind, logic [KEY_W-1:0] k, logic [IDX_W-1:0] lookup);
    start           = 1'b1;
    in_kind         = kind;
    in_key          = k;
    in_lookup_index = lookup;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    replies_due.push_back(compute_reply(kind, k, lookup));
    items_sent++;
    if (kind == KIND_READ) reads_sent++;
    else interns_sent++;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35 && shadow_held > 0)
      send_item(KIND_INTERN, shadow_idx_key[$urandom_range(0, shadow_held - 1)],
                IDX_W'($urandom));
    else if (pick < 60)
      send_item(KIND_INTERN, {$urandom, $urandom}, IDX_W'($urandom));
    else if (pick < 65)
      send_item(KIND_INTERN, '0, IDX_W'($urandom));
    else if (pick < 90 && shadow_held > 0)
      send_item(KIND_READ, {$urandom, $urandom},
                IDX_W'($urandom_range(0, shadow_held - 1)));
    else
      send_item(KIND_READ, {$urandom, $urandom}, IDX_W'($urandom));
  endtask

  task automatic test_directed();
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] chain [5];
    logic [SLOT_BITS-1:0] target;
    int n;
    gap_pct = 25;
    send_item(KIND_READ, '1, '0);
    send_item(KIND_INTERN, '0, '1);
    send_item(KIND_INTERN, 64'h1, '0);
    send_item(KIND_INTERN, '1, '1);
    send_item(KIND_INTERN, 64'h8000_0000_0000_0000, '0);
    send_item(KIND_INTERN, 64'h6D61_696E_5F73_796D, '0);
    send_item(KIND_INTERN, 64'h1, '1);
    send_item(KIND_INTERN, '1, '0);
    send_item(KIND_READ, '0, '0);
    send_item(KIND_READ, '1, IDX_W'(3));
    send_item(KIND_READ, '0, IDX_W'(4));
    send_item(KIND_READ, '1, '1);
    send_item(KIND_INTERN, '0, '0);
    // keys sharing the home slot of key 1
    target = home_slot_of(64'h1);
    for (n = 0; n < 2; n++) begin
      do k = {$urandom, $urandom}; while (home_slot_of(k) != target || k == 64'h1);
      chain[n] = k;
      send_item(KIND_INTERN, k, IDX_W'($urandom));
    end
    // chain at the last slot, probing wraps to slot zero
    for (n = 2; n < 5; n++) begin
      do k = {$urandom, $urandom}; while (home_slot_of(k) != SLOTS - 1);
      chain[n] = k;
      send_item(KIND_INTERN, k, IDX_W'($urandom));
    end
    send_item(KIND_INTERN, chain[1], IDX_W'($urandom));
    send_item(KIND_INTERN, chain[4], IDX_W'($urandom));
    send_item(KIND_READ, {$urandom, $urandom}, IDX_W'(shadow_held - 1'b1));
    send_item(KIND_READ, {$urandom, $urandom}, shadow_held[IDX_W-1:0]);
  endtask

  task automatic test_random_mix(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 64 == 0) gap_pct = $urandom_range(0, 1) ? 30 : 0;
      send_random_item();
    end
  endtask

  task automatic test_fill_to_capacity();
    gap_pct = 20;
    while (shadow_held < SYMBOL_CAP)
      send_item(KIND_INTERN, {$urandom, $urandom}, IDX_W'($urandom));
    send_item(KIND_INTERN, {$urandom, $urandom}, IDX_W'($urandom));
    send_item(KIND_INTERN, shadow_idx_key[SYMBOL_CAP - 1], IDX_W'($urandom));
    send_item(KIND_READ, {$urandom, $urandom}, IDX_W'(SYMBOL_CAP - 1));
  endtask

  task automatic test_random_full(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i < count / 2) begin
        if (i % 64 == 0) gap_pct = $urandom_range(0, 1) ? 30 : 0;
      end else begin
        gap_pct = 0;
      end
      send_random_item();
    end
  endtask

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result with none expected", 64'(out_symbol_index), '0);
      end else begin
        want = replies_due.pop_front();
        if (out_symbol_index !== want.sym_index)
          report_mismatch("symbol_index", 64'(out_symbol_index), 64'(want.sym_index));
        if (out_valid_res !== want.valid)
          report_mismatch("valid_res", 64'(out_valid_res), 64'(want.valid));
        if (out_newly_added !== want.added)
          report_mismatch("newly_added", 64'(out_newly_added), 64'(want.added));
        if (out_name_key !== want.name_key)
          report_mismatch("name_key", out_name_key, want.name_key);
        if (out_symbols_held !== want.held)
          report_mismatch("symbols_held", 64'(out_symbols_held), 64'(want.held));
        if (out_drops_seen !== want.drops)
          report_mismatch("drops_seen", 64'(out_drops_seen), 64'(want.drops));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || out_strobe === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles, %0d results outstanding",
                 stall_cycles, replies_due.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int s;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_INTERN;
    in_key          = '0;
    in_lookup_index = '0;
    mismatches      = 0;
    items_sent      = 0;
    interns_sent    = 0;
    reads_sent      = 0;
    gap_pct         = 0;
    stall_cycles    = 0;
    shadow_held     = '0;
    shadow_drops    = '0;
    for (s = 0; s < SLOTS; s++) begin
      shadow_slot_key[s] = '0;
      shadow_slot_idx[s] = '0;
    end
    for (s = 0; s < SYMBOL_CAP; s++) shadow_idx_key[s] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix(1000);
    test_fill_to_capacity();
    test_random_full(800);

    start = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d interns, %0d read-backs", items_sent, interns_sent,
             reads_sent);
    $display("Table ended with %0d symbols held and %0d refused interns", shadow_held,
             shadow_drops);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sih_pkg.sv
design/symbol_interning_hash_table.sv
verif/testbench.sv
